// ===== hw/rtl/stepper_tone_head_driver_defines.svh =====
// assertion macros for the stepper tone head driver
// used by stepper_tone_head_driver.sv; no other dependencies
`ifndef STEPPER_TONE_HEAD_DRIVER_DEFINES_SVH
`define STEPPER_TONE_HEAD_DRIVER_DEFINES_SVH

// same-cycle implication, disabled during reset
`define STHD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define STHD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/sthd_pkg.sv =====
// shared types and constants for the stepper tone head driver
// no dependencies; imported by stepper_tone_head_driver
`timescale 1ns / 1ps

package sthd_pkg;

   // request codes
   localparam logic [1:0] REQ_TICK     = 2'd0;
   localparam logic [1:0] REQ_NOTE_ON  = 2'd1;
   localparam logic [1:0] REQ_NOTE_OFF = 2'd2;

   // head turns when room ahead is at or below this margin
   localparam int unsigned END_MARGIN = 10;

   // track length after reset
   localparam logic [7:0] TRACK_RESET = 8'd80;

   // remainder unit works on a 17 bit sum, one bit per cycle
   localparam int unsigned DIV_BITS   = 17;
   localparam int unsigned DIV_CNT_W  = $clog2(DIV_BITS);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_DIV,
      ST_DONE
   } sthd_state_type;

endpackage

// ===== hw/rtl/stepper_tone_head_driver.sv =====
// stepper tone head driver: sequencer with a shared remainder unit
// depends on sthd_pkg and stepper_tone_head_driver_defines.svh
`timescale 1ns / 1ps
`include "stepper_tone_head_driver_defines.svh"

// Drives a stepper head as a tone source.
// req channel (valid/ready): one transaction per request, req_type selects
// tick (adds req_elapsed_time), note on (loads pitch and half period, zero
// velocity releases) or note off. Every request gives exactly one rsp
// transaction holding step level, direction, head position, playing flag
// and sounding pitch as they stand after the request.
// csr channel: writes the track length; always ready, write only while idle.
// Sequence: a request is captured on acceptance, executed in ST_EXEC and its
// result written to the output register in ST_DONE; a tick that toggles the
// step line passes through ST_DIV between them, where the remainder of the
// 17 bit time sum by the half period is formed one bit per cycle in a single
// compare-subtract unit.
// One request at a time: req_ready is low from acceptance until the result is
// written to the output register.
// If the receiver stalls, the result waits in the output register; the next
// request is accepted meanwhile and its result waits until the register frees.
// Reset (synchronous): head at position 0 moving up, silent, track length 80.
module stepper_tone_head_driver (
   input  logic       clock,
   input  logic       reset,
   // request channel
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_type,
   input  logic [15:0] req_elapsed_time,
   input  logic [6:0] req_note_pitch,
   input  logic [6:0] req_note_velocity,
   input  logic [15:0] req_half_period,
   // result channel
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_step_level,
   output logic       rsp_direction_level,
   output logic [7:0] rsp_head_position,
   output logic       rsp_playing,
   output logic [6:0] rsp_playing_pitch,
   // configuration write
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [7:0] csr_track_positions
);

   import sthd_pkg::*;

   // sequencer
   sthd_state_type state_ff, state_in;

   // captured request
   logic [1:0]  op_kind_ff;
   logic [15:0] op_elapsed_ff;
   logic [6:0]  op_pitch_ff;
   logic [6:0]  op_velocity_ff;
   logic [15:0] op_half_ff;

   // head and note state
   logic [7:0]  track_ff;
   logic        step_phase_ff, step_phase_in;
   logic        move_up_ff, move_up_in;
   logic [7:0]  position_ff, position_in;
   logic        active_ff, active_in;
   logic [6:0]  pitch_ff, pitch_in;
   logic [15:0] half_ff, half_in;
   logic [15:0] accum_ff, accum_in;
   logic [15:0] steps_ff, steps_in;

   // remainder unit
   logic [15:0]          div_rem_ff, div_rem_in;
   logic [DIV_BITS-1:0]  div_num_ff, div_num_in;
   logic [DIV_CNT_W-1:0] div_cnt_ff, div_cnt_in;

   // output register
   logic        rsp_valid_ff, rsp_valid_in;
   logic        out_step_ff, out_step_in;
   logic        out_dir_ff, out_dir_in;
   logic [7:0]  out_pos_ff, out_pos_in;
   logic        out_play_ff, out_play_in;
   logic [6:0]  out_pitch_ff, out_pitch_in;

   // toggle datapath
   logic        flip_phase;
   logic [7:0]  flip_pos;
   logic [15:0] flip_steps;
   logic signed [9:0] flip_room;
   logic        flip_turn;
   logic [16:0] tick_sum;

   // release datapath
   logic signed [9:0]  rel_room;
   logic signed [17:0] rel_taken;
   logic signed [17:0] rel_room_w;
   logic signed [17:0] rel_other;
   logic        rel_match;
   logic        rel_turn;

   // shared compare-subtract
   logic [16:0] div_trial;
   logic [16:0] div_diff;
   logic        div_take;
   logic [15:0] div_rem_next;

   logic        req_fire;
   logic        out_free;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_step_level      = out_step_ff;
   assign rsp_direction_level = out_dir_ff;
   assign rsp_head_position   = out_pos_ff;
   assign rsp_playing         = out_play_ff;
   assign rsp_playing_pitch   = out_pitch_ff;

   // step toggle: move on rising edge, then check room ahead
   always_comb begin
      flip_phase = !step_phase_ff;
      flip_pos   = position_ff;
      flip_steps = steps_ff;
      if (flip_phase) begin
         if (steps_ff != 16'hFFFF) begin
            flip_steps = steps_ff + 16'd1;
         end
         if (move_up_ff) begin
            if (position_ff != 8'hFF) begin
               flip_pos = position_ff + 8'd1;
            end
         end else begin
            if (position_ff != 8'h00) begin
               flip_pos = position_ff - 8'd1;
            end
         end
      end
      if (move_up_ff) begin
         flip_room = $signed({2'b00, track_ff}) - $signed({2'b00, flip_pos}) - 10'sd1;
      end else begin
         flip_room = $signed({2'b00, flip_pos});
      end
      flip_turn = (flip_room <= $signed(10'(END_MARGIN)));
      tick_sum  = {1'b0, accum_ff} + {1'b0, op_elapsed_ff};
   end

   // release: may turn toward the side with more room
   always_comb begin
      if (move_up_ff) begin
         rel_room = $signed({2'b00, track_ff}) - $signed({2'b00, position_ff}) - 10'sd1;
      end else begin
         rel_room = $signed({2'b00, position_ff});
      end
      rel_taken  = $signed({2'b00, steps_ff});
      rel_room_w = 18'(rel_room);
      rel_other  = $signed({10'd0, track_ff}) - rel_room_w;
      rel_match  = active_ff && (op_pitch_ff == pitch_ff);
      rel_turn   = (rel_room_w < rel_taken) && (rel_other > rel_taken);
   end

   // one restoring step of the remainder
   always_comb begin
      div_trial    = {div_rem_ff, div_num_ff[DIV_BITS-1]};
      div_diff     = div_trial - {1'b0, half_ff};
      div_take     = (div_trial >= {1'b0, half_ff});
      div_rem_next = div_take ? div_diff[15:0] : div_trial[15:0];
   end

   // sequencer next state
   always_comb begin
      state_in      = state_ff;
      step_phase_in = step_phase_ff;
      move_up_in    = move_up_ff;
      position_in   = position_ff;
      active_in     = active_ff;
      pitch_in      = pitch_ff;
      half_in       = half_ff;
      accum_in      = accum_ff;
      steps_in      = steps_ff;
      div_rem_in    = div_rem_ff;
      div_num_in    = div_num_ff;
      div_cnt_in    = div_cnt_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      out_step_in   = out_step_ff;
      out_dir_in    = out_dir_ff;
      out_pos_in    = out_pos_ff;
      out_play_in   = out_play_ff;
      out_pitch_in  = out_pitch_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in = ST_DONE;
            case (op_kind_ff)
               REQ_TICK: begin
                  if (active_ff) begin
                     if (tick_sum >= {1'b0, half_ff}) begin
                        step_phase_in = flip_phase;
                        position_in   = flip_pos;
                        steps_in      = flip_steps;
                        move_up_in    = move_up_ff ^ flip_turn;
                        div_num_in    = tick_sum;
                        div_rem_in    = '0;
                        div_cnt_in    = '0;
                        state_in      = ST_DIV;
                     end else begin
                        accum_in = tick_sum[15:0];
                     end
                  end
               end
               REQ_NOTE_ON, REQ_NOTE_OFF: begin
                  if (op_kind_ff == REQ_NOTE_ON && op_velocity_ff != 7'd0) begin
                     active_in = 1'b1;
                     pitch_in  = op_pitch_ff;
                     half_in   = (op_half_ff == 16'd0) ? 16'd1 : op_half_ff;
                  end else if (rel_match) begin
                     step_phase_in = 1'b0;
                     active_in     = 1'b0;
                     pitch_in      = '0;
                     half_in       = '0;
                     accum_in      = '0;
                     steps_in      = '0;
                     move_up_in    = move_up_ff ^ rel_turn;
                  end
               end
               default: begin
               end
            endcase
         end
         ST_DIV: begin
            div_rem_in = div_rem_next;
            div_num_in = {div_num_ff[DIV_BITS-2:0], 1'b0};
            div_cnt_in = div_cnt_ff + 1'b1;
            if (div_cnt_ff == DIV_CNT_W'(DIV_BITS - 1)) begin
               accum_in = div_rem_next;
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               out_step_in  = step_phase_ff;
               out_dir_in   = move_up_ff;
               out_pos_in   = position_ff;
               out_play_in  = active_ff;
               out_pitch_in = active_ff ? pitch_ff : 7'd0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control and architectural state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         track_ff      <= TRACK_RESET;
         step_phase_ff <= 1'b0;
         move_up_ff    <= 1'b1;
         position_ff   <= '0;
         active_ff     <= 1'b0;
         pitch_ff      <= '0;
         half_ff       <= '0;
         accum_ff      <= '0;
         steps_ff      <= '0;
         div_cnt_ff    <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         step_phase_ff <= step_phase_in;
         move_up_ff    <= move_up_in;
         position_ff   <= position_in;
         active_ff     <= active_in;
         pitch_ff      <= pitch_in;
         half_ff       <= half_in;
         accum_ff      <= accum_in;
         steps_ff      <= steps_in;
         div_cnt_ff    <= div_cnt_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            track_ff <= csr_track_positions;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         op_kind_ff     <= req_type;
         op_elapsed_ff  <= req_elapsed_time;
         op_pitch_ff    <= req_note_pitch;
         op_velocity_ff <= req_note_velocity;
         op_half_ff     <= req_half_period;
      end
      div_rem_ff   <= div_rem_in;
      div_num_ff   <= div_num_in;
      out_step_ff  <= out_step_in;
      out_dir_ff   <= out_dir_in;
      out_pos_ff   <= out_pos_in;
      out_play_ff  <= out_play_in;
      out_pitch_ff <= out_pitch_in;
   end

   // checks
   `STHD_ASSERT_NOW(a_silent_clear, clock, reset, !active_ff,
      (accum_ff == 16'd0) && !step_phase_ff && (steps_ff == 16'd0), "silent state not cleared")
   `STHD_ASSERT_NOW(a_half_nonzero, clock, reset, active_ff,
      half_ff != 16'd0, "active note with zero half period")
   `STHD_ASSERT_NOW(a_rem_bound, clock, reset, state_ff == ST_DIV,
      div_rem_ff < half_ff, "partial remainder not below half period")
   `STHD_ASSERT_NEXT(a_div_exit, clock, reset, state_ff == ST_DIV,
      (state_ff == ST_DIV) || (state_ff == ST_DONE), "remainder unit left early")

endmodule
